// ===== hdl/vfrt_pkg.sv =====
// Shared widths and defaults for the video frame reassembly tracker.
package vfrt_pkg;

	localparam int TIME_BITS_DEF = 48;
	localparam int TIME_BITS_MIN = 16;
	localparam int TIME_BITS_MAX = 64;

	localparam int FRAME_NUM_W = 16;
	localparam int FRAG_NUM_W  = 8;
	localparam int SIZE_W      = 32;
	localparam int STAMP_W     = 32;
	localparam int LEN_W       = 16;
	localparam int CNT_W       = 32;
	localparam int BYTES_W     = 64;

endpackage

// ===== hdl/vfrt_pkt_if.sv =====
// Packet request channel: valid, ready and the received packet fields.
interface vfrt_pkt_if #(
	parameter int TIME_BITS = vfrt_pkg::TIME_BITS_DEF
);
	logic                             valid;
	logic                             ready;
	logic                             has_header;
	logic                             starts_frame;
	logic                             ends_frame;
	logic [vfrt_pkg::SIZE_W-1:0]      frag_size;
	logic [vfrt_pkg::FRAME_NUM_W-1:0] frame_number;
	logic                             intra_frame;
	logic [vfrt_pkg::STAMP_W-1:0]     send_time;
	logic [vfrt_pkg::FRAG_NUM_W-1:0]  frag_number;
	logic [vfrt_pkg::LEN_W-1:0]       payload_len;
	logic [TIME_BITS-1:0]             arrival_time;

	modport source (
		output valid, has_header, starts_frame, ends_frame, frag_size, frame_number,
		       intra_frame, send_time, frag_number, payload_len, arrival_time,
		input  ready
	);
	modport sink (
		input  valid, has_header, starts_frame, ends_frame, frag_size, frame_number,
		       intra_frame, send_time, frag_number, payload_len, arrival_time,
		output ready
	);
endinterface

// ===== hdl/vfrt_rpt_if.sv =====
// Frame report channel: valid, ready and the completed frame record with statistics.
interface vfrt_rpt_if #(
	parameter int TIME_BITS = vfrt_pkg::TIME_BITS_DEF
);
	logic                             valid;
	logic                             ready;
	logic [vfrt_pkg::FRAME_NUM_W-1:0] done_frame_number;
	logic                             done_intra;
	logic [vfrt_pkg::SIZE_W-1:0]      done_size;
	logic [vfrt_pkg::CNT_W-1:0]       done_frags;
	logic [vfrt_pkg::CNT_W-1:0]       done_packets;
	logic [TIME_BITS-1:0]             first_arrival;
	logic [TIME_BITS-1:0]             last_arrival;
	logic [vfrt_pkg::STAMP_W-1:0]     done_send_time;
	logic [vfrt_pkg::CNT_W-1:0]       i_frames_total;
	logic [vfrt_pkg::CNT_W-1:0]       p_frames_total;
	logic [vfrt_pkg::BYTES_W-1:0]     i_bytes_total;
	logic [vfrt_pkg::BYTES_W-1:0]     p_bytes_total;

	modport source (
		output valid, done_frame_number, done_intra, done_size, done_frags, done_packets,
		       first_arrival, last_arrival, done_send_time, i_frames_total,
		       p_frames_total, i_bytes_total, p_bytes_total,
		input  ready
	);
	modport sink (
		input  valid, done_frame_number, done_intra, done_size, done_frags, done_packets,
		       first_arrival, last_arrival, done_send_time, i_frames_total,
		       p_frames_total, i_bytes_total, p_bytes_total,
		output ready
	);
endinterface

// ===== hdl/vfrt_in_reg.sv =====
// Input register stage that captures one packet request per cycle while it is empty or its contents move on.
module vfrt_in_reg #(
	parameter int TIME_BITS = vfrt_pkg::TIME_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	vfrt_pkt_if.sink   up,
	vfrt_pkt_if.source dn
);
	logic                             valid_s1;
	logic                             has_header_s1;
	logic                             starts_frame_s1;
	logic                             ends_frame_s1;
	logic [vfrt_pkg::SIZE_W-1:0]      frag_size_s1;
	logic [vfrt_pkg::FRAME_NUM_W-1:0] frame_number_s1;
	logic                             intra_frame_s1;
	logic [vfrt_pkg::STAMP_W-1:0]     send_time_s1;
	logic [vfrt_pkg::FRAG_NUM_W-1:0]  frag_number_s1;
	logic [vfrt_pkg::LEN_W-1:0]       payload_len_s1;
	logic [TIME_BITS-1:0]             arrival_time_s1;

	// The stage refills in the same cycle that its contents move on.
	assign up.ready = !valid_s1 || dn.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up.ready) begin
			valid_s1 <= up.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up.ready && up.valid) begin
			has_header_s1   <= up.has_header;
			starts_frame_s1 <= up.starts_frame;
			ends_frame_s1   <= up.ends_frame;
			frag_size_s1    <= up.frag_size;
			frame_number_s1 <= up.frame_number;
			intra_frame_s1  <= up.intra_frame;
			send_time_s1    <= up.send_time;
			frag_number_s1  <= up.frag_number;
			payload_len_s1  <= up.payload_len;
			arrival_time_s1 <= up.arrival_time;
		end
	end

	assign dn.valid        = valid_s1;
	assign dn.has_header   = has_header_s1;
	assign dn.starts_frame = starts_frame_s1;
	assign dn.ends_frame   = ends_frame_s1;
	assign dn.frag_size    = frag_size_s1;
	assign dn.frame_number = frame_number_s1;
	assign dn.intra_frame  = intra_frame_s1;
	assign dn.send_time    = send_time_s1;
	assign dn.frag_number  = frag_number_s1;
	assign dn.payload_len  = payload_len_s1;
	assign dn.arrival_time = arrival_time_s1;
endmodule

// ===== hdl/vfrt_tracker.sv =====
// Frame record and statistics registers with their combinational update logic.
module vfrt_tracker #(
	parameter int TIME_BITS = vfrt_pkg::TIME_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	vfrt_pkt_if.sink   pkt,
	vfrt_rpt_if.source rpt
);
	logic                             receiving_q,  receiving_d;
	logic                             last_seen_q,  last_seen_d;
	logic [vfrt_pkg::FRAME_NUM_W-1:0] frame_num_q,  frame_num_d;
	logic                             intra_q,      intra_d;
	logic [vfrt_pkg::STAMP_W-1:0]     send_time_q,  send_time_d;
	logic [vfrt_pkg::SIZE_W-1:0]      size_q,       size_d;
	logic [vfrt_pkg::CNT_W-1:0]       frags_q,      frags_d;
	logic [vfrt_pkg::CNT_W-1:0]       packets_q,    packets_d;
	logic [TIME_BITS-1:0]             first_q,      first_d;
	logic [TIME_BITS-1:0]             last_q,       last_d;
	logic [vfrt_pkg::SIZE_W-1:0]      frag_exp_q,   frag_exp_d;
	logic [vfrt_pkg::SIZE_W-1:0]      frag_rcv_q,   frag_rcv_d;
	logic [vfrt_pkg::CNT_W-1:0]       i_count_q,    i_count_d;
	logic [vfrt_pkg::CNT_W-1:0]       p_count_q,    p_count_d;
	logic [vfrt_pkg::BYTES_W-1:0]     i_bytes_q,    i_bytes_d;
	logic [vfrt_pkg::BYTES_W-1:0]     p_bytes_q,    p_bytes_d;
	logic                             complete;
	logic                             take;

	assign pkt.ready = rpt.ready;
	assign take      = pkt.valid && pkt.ready;

	always_comb begin
		receiving_d = receiving_q;
		last_seen_d = last_seen_q;
		frame_num_d = frame_num_q;
		intra_d     = intra_q;
		send_time_d = send_time_q;
		size_d      = size_q;
		frags_d     = frags_q;
		packets_d   = packets_q;
		first_d     = first_q;
		last_d      = last_q;
		frag_exp_d  = frag_exp_q;
		frag_rcv_d  = frag_rcv_q;
		i_count_d   = i_count_q;
		p_count_d   = p_count_q;
		i_bytes_d   = i_bytes_q;
		p_bytes_d   = p_bytes_q;
		complete    = 1'b0;

		// A start mark drops whatever frame is open and begins a fresh record.
		if (pkt.has_header && pkt.starts_frame) begin
			receiving_d = 1'b1;
			last_seen_d = 1'b0;
			first_d     = pkt.arrival_time;
			last_d      = pkt.arrival_time;
			size_d      = '0;
			frags_d     = '0;
			packets_d   = '0;
			frame_num_d = pkt.frame_number;
			intra_d     = pkt.intra_frame;
			send_time_d = pkt.send_time;
		end

		// Headers outside an open frame are ignored.
		if (pkt.has_header && receiving_d) begin
			size_d     = size_d + pkt.frag_size;
			frags_d    = frags_d + vfrt_pkg::CNT_W'(1);
			frag_exp_d = pkt.frag_size;
			frag_rcv_d = '0;
			if (pkt.ends_frame) begin
				last_seen_d = 1'b1;
			end
		end

		if (receiving_d) begin
			packets_d  = packets_d + vfrt_pkg::CNT_W'(1);
			frag_rcv_d = frag_rcv_d
				+ {{(vfrt_pkg::SIZE_W - vfrt_pkg::LEN_W){1'b0}}, pkt.payload_len};
			if (pkt.arrival_time < first_d) begin
				first_d = pkt.arrival_time;
			end
			if (pkt.arrival_time > last_d) begin
				last_d = pkt.arrival_time;
			end
			complete = (frag_rcv_d == frag_exp_d) && last_seen_d;
		end

		if (complete) begin
			receiving_d = 1'b0;
			if (intra_d) begin
				i_count_d = i_count_q + vfrt_pkg::CNT_W'(1);
				i_bytes_d = i_bytes_q
					+ {{(vfrt_pkg::BYTES_W - vfrt_pkg::SIZE_W){1'b0}}, size_d};
			end else begin
				p_count_d = p_count_q + vfrt_pkg::CNT_W'(1);
				p_bytes_d = p_bytes_q
					+ {{(vfrt_pkg::BYTES_W - vfrt_pkg::SIZE_W){1'b0}}, size_d};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q <= 1'b0;
			last_seen_q <= 1'b0;
			frame_num_q <= '0;
			intra_q     <= 1'b0;
			send_time_q <= '0;
			size_q      <= '0;
			frags_q     <= '0;
			packets_q   <= '0;
			first_q     <= '0;
			last_q      <= '0;
			frag_exp_q  <= '0;
			frag_rcv_q  <= '0;
			i_count_q   <= '0;
			p_count_q   <= '0;
			i_bytes_q   <= '0;
			p_bytes_q   <= '0;
		end else if (take) begin
			receiving_q <= receiving_d;
			last_seen_q <= last_seen_d;
			frame_num_q <= frame_num_d;
			intra_q     <= intra_d;
			send_time_q <= send_time_d;
			size_q      <= size_d;
			frags_q     <= frags_d;
			packets_q   <= packets_d;
			first_q     <= first_d;
			last_q      <= last_d;
			frag_exp_q  <= frag_exp_d;
			frag_rcv_q  <= frag_rcv_d;
			i_count_q   <= i_count_d;
			p_count_q   <= p_count_d;
			i_bytes_q   <= i_bytes_d;
			p_bytes_q   <= p_bytes_d;
		end
	end

	assign rpt.valid             = pkt.valid && complete;
	assign rpt.done_frame_number = frame_num_d;
	assign rpt.done_intra        = intra_d;
	assign rpt.done_size         = size_d;
	assign rpt.done_frags        = frags_d;
	assign rpt.done_packets      = packets_d;
	assign rpt.first_arrival     = first_d;
	assign rpt.last_arrival      = last_d;
	assign rpt.done_send_time    = send_time_d;
	assign rpt.i_frames_total    = i_count_d;
	assign rpt.p_frames_total    = p_count_d;
	assign rpt.i_bytes_total     = i_bytes_d;
	assign rpt.p_bytes_total     = p_bytes_d;
endmodule

// ===== hdl/vfrt_out_reg.sv =====
// Result register that holds one frame report until it is taken.
module vfrt_out_reg #(
	parameter int TIME_BITS = vfrt_pkg::TIME_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	vfrt_rpt_if.sink   up,
	vfrt_rpt_if.source dn
);
	logic                             valid_q;
	logic [vfrt_pkg::FRAME_NUM_W-1:0] frame_num_q;
	logic                             intra_q;
	logic [vfrt_pkg::SIZE_W-1:0]      size_q;
	logic [vfrt_pkg::CNT_W-1:0]       frags_q;
	logic [vfrt_pkg::CNT_W-1:0]       packets_q;
	logic [TIME_BITS-1:0]             first_q;
	logic [TIME_BITS-1:0]             last_q;
	logic [vfrt_pkg::STAMP_W-1:0]     send_time_q;
	logic [vfrt_pkg::CNT_W-1:0]       i_count_q;
	logic [vfrt_pkg::CNT_W-1:0]       p_count_q;
	logic [vfrt_pkg::BYTES_W-1:0]     i_bytes_q;
	logic [vfrt_pkg::BYTES_W-1:0]     p_bytes_q;

	assign up.ready = !valid_q || dn.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up.ready) begin
			valid_q <= up.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up.ready && up.valid) begin
			frame_num_q <= up.done_frame_number;
			intra_q     <= up.done_intra;
			size_q      <= up.done_size;
			frags_q     <= up.done_frags;
			packets_q   <= up.done_packets;
			first_q     <= up.first_arrival;
			last_q      <= up.last_arrival;
			send_time_q <= up.done_send_time;
			i_count_q   <= up.i_frames_total;
			p_count_q   <= up.p_frames_total;
			i_bytes_q   <= up.i_bytes_total;
			p_bytes_q   <= up.p_bytes_total;
		end
	end

	assign dn.valid             = valid_q;
	assign dn.done_frame_number = frame_num_q;
	assign dn.done_intra        = intra_q;
	assign dn.done_size         = size_q;
	assign dn.done_frags        = frags_q;
	assign dn.done_packets      = packets_q;
	assign dn.first_arrival     = first_q;
	assign dn.last_arrival      = last_q;
	assign dn.done_send_time    = send_time_q;
	assign dn.i_frames_total    = i_count_q;
	assign dn.p_frames_total    = p_count_q;
	assign dn.i_bytes_total     = i_bytes_q;
	assign dn.p_bytes_total     = p_bytes_q;
endmodule

// ===== hdl/video_frame_reassembly_tracker_core.sv =====
// Video frame reassembly tracker: follows packets into frames and reports each completed frame.
// The block takes one packet request per clock and emits a frame report when a frame's last
// fragment is completely received; packets that complete nothing give no report. A packet
// passes an input register, then the frame record and I/P statistics are updated from it,
// and any report lands in a result register. Throughput is one packet per cycle while no
// report waits untaken on the output; the input side keeps accepting while a report waits
// on the output, until both registers are full. TIME_BITS (16 to 64) sets the width of
// arrival times.
module video_frame_reassembly_tracker_core #(
	parameter int TIME_BITS = vfrt_pkg::TIME_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	vfrt_pkt_if.sink   pkt,
	vfrt_rpt_if.source rpt
);
	vfrt_pkt_if #(.TIME_BITS(TIME_BITS)) pkt_s1 ();
	vfrt_rpt_if #(.TIME_BITS(TIME_BITS)) rpt_new ();

	vfrt_in_reg #(.TIME_BITS(TIME_BITS)) u_in_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.up     (pkt),
		.dn     (pkt_s1)
	);

	vfrt_tracker #(.TIME_BITS(TIME_BITS)) u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt_s1),
		.rpt    (rpt_new)
	);

	vfrt_out_reg #(.TIME_BITS(TIME_BITS)) u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.up     (rpt_new),
		.dn     (rpt)
	);
endmodule
